FILE: rtl/cale_pkg.sv
// Command codes, status codes and fixed field widths of the circular array list engine.
// No dependencies; used by circular_array_list_engine.
package cale_pkg;

  localparam int CMD_W  = 4;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_GET        = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SET        = 4'd4;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CONTAINS   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

endpackage

FILE: rtl/circular_array_list_engine.sv
// Push, clear and failing commands go from S_IDLE straight to S_DONE; get, set and pops
// pass through S_READ; insert and remove_at shift n entries (n at most CAPACITY/2) in
// S_MOVE, insert then writing its item in S_FINAL; contains scans up to count entries.
// One command at a time: a new command is taken only once the last result has been loaded;
// the move/scan loop walks the ring store one entry a cycle. Synchronous reset clears
// head, count and the handshake state; store contents are not cleared.
// Indexed list in a ring store with a shared move/scan sequencer; uses cale_pkg.
module circular_array_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [cale_pkg::CMD_W-1:0]   cmd,
  input  logic [cale_pkg::POS_W-1:0]   position,
  input  logic [cale_pkg::VAL_W-1:0]   item_value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [cale_pkg::STAT_W-1:0]  status,
  output logic [cale_pkg::VAL_W-1:0]   read_value,
  output logic                         found,
  output logic [cale_pkg::CNT_W-1:0]   count
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > cale_pkg::POS_W) ? CW : cale_pkg::POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                  state, state_next;
  logic [SW-1:0]               head, head_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic [SW-1:0]               src, src_next;
  logic [SW-1:0]               wr_addr, wr_addr_next;
  logic [SW-1:0]               fin_addr, fin_addr_next;
  logic [CW-1:0]               left, left_next;
  logic                        step_up, step_up_next;
  logic                        pend, pend_next;
  logic [cale_pkg::CMD_W-1:0]  cmd_q, cmd_q_next;
  logic [DATA_WIDTH-1:0]       val_q, val_q_next;
  logic [DATA_WIDTH-1:0]       res_rd, res_rd_next;
  logic [cale_pkg::STAT_W-1:0] res_status, res_status_next;
  logic                        res_found, res_found_next;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic                  mem_we;
  logic [SW-1:0]         mem_waddr;
  logic [SW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                  accept;
  logic                  out_load;
  logic [63:0]           item_wide;
  logic [63:0]           rd_wide;
  logic [31:0]           cnt_wide;
  logic [DATA_WIDTH-1:0] val_in;
  logic [SW-1:0]         pos_slot;
  logic [SW-1:0]         cnt_slot;
  logic [MW-1:0]         pos_ext;
  logic [MW-1:0]         cnt_ext;
  logic                  full;
  logic                  empty;
  logic                  ins_front;
  logic                  rem_front;
  logic [SW-1:0]         step_dst;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_load  = (state == S_DONE) && (!result_valid || !result_stall);

  assign item_wide = 64'(item_value);
  assign val_in    = item_wide[DATA_WIDTH-1:0];
  assign rd_wide   = 64'(res_rd);
  assign cnt_wide  = 32'(cnt);
  assign pos_slot  = SW'(position);
  assign cnt_slot  = SW'(cnt);
  assign pos_ext   = MW'(position);
  assign cnt_ext   = MW'(cnt);
  assign full      = (cnt == CW'(CAPACITY));
  assign empty     = (cnt == '0);
  // shift the shorter side: front when 2*pos < count (insert) or 2*pos+1 < count (remove)
  assign ins_front = {pos_ext, 1'b0} < {1'b0, cnt_ext};
  assign rem_front = {pos_ext, 1'b1} < {1'b0, cnt_ext};
  // destination of a move sits one slot against the walk direction
  assign step_dst  = step_up ? (src - SW'(1)) : (src + SW'(1));

  always_comb begin
    state_next      = state;
    head_next       = head;
    cnt_next        = cnt;
    src_next        = src;
    wr_addr_next    = wr_addr;
    fin_addr_next   = fin_addr;
    left_next       = left;
    step_up_next    = step_up;
    pend_next       = pend;
    cmd_q_next      = cmd_q;
    val_q_next      = val_q;
    res_rd_next     = res_rd;
    res_status_next = res_status;
    res_found_next  = res_found;
    mem_we          = 1'b0;
    mem_waddr       = wr_addr;
    mem_wdata       = mem_rdata;
    mem_raddr       = src;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q_next      = cmd;
          val_q_next      = val_in;
          res_rd_next     = '0;
          res_found_next  = 1'b0;
          res_status_next = cale_pkg::ST_OK;
          pend_next       = 1'b0;
          state_next      = S_DONE;
          case (cmd)
            cale_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                res_status_next = cale_pkg::ST_FULL;
              end else begin
                head_next = head - SW'(1);
                mem_we    = 1'b1;
                mem_waddr = head - SW'(1);
                mem_wdata = val_in;
                cnt_next  = cnt + CW'(1);
              end
            end
            cale_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                res_status_next = cale_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head + cnt_slot;
                mem_wdata = val_in;
                cnt_next  = cnt + CW'(1);
              end
            end
            cale_pkg::CMD_INSERT: begin
              if (full) begin
                res_status_next = cale_pkg::ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                res_status_next = cale_pkg::ST_RANGE;
              end else begin
                if (ins_front) begin
                  src_next      = head;
                  step_up_next  = 1'b1;
                  left_next     = CW'(pos_ext);
                  fin_addr_next = head + pos_slot - SW'(1);
                  head_next     = head - SW'(1);
                end else begin
                  src_next      = head + cnt_slot - SW'(1);
                  step_up_next  = 1'b0;
                  left_next     = CW'(cnt_ext - pos_ext);
                  fin_addr_next = head + pos_slot;
                end
                cnt_next   = cnt + CW'(1);
                state_next = S_MOVE;
              end
            end
            cale_pkg::CMD_GET: begin
              if (pos_ext >= cnt_ext) begin
                res_status_next = cale_pkg::ST_RANGE;
              end else begin
                mem_raddr  = head + pos_slot;
                state_next = S_READ;
              end
            end
            cale_pkg::CMD_SET: begin
              if (pos_ext >= cnt_ext) begin
                res_status_next = cale_pkg::ST_RANGE;
              end else begin
                // registered read returns the old value in the same cycle as the write
                mem_raddr  = head + pos_slot;
                mem_we     = 1'b1;
                mem_waddr  = head + pos_slot;
                mem_wdata  = val_in;
                state_next = S_READ;
              end
            end
            cale_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                res_status_next = cale_pkg::ST_EMPTY;
              end else begin
                mem_raddr  = head;
                head_next  = head + SW'(1);
                cnt_next   = cnt - CW'(1);
                state_next = S_READ;
              end
            end
            cale_pkg::CMD_POP_BACK: begin
              if (empty) begin
                res_status_next = cale_pkg::ST_EMPTY;
              end else begin
                mem_raddr  = head + cnt_slot - SW'(1);
                cnt_next   = cnt - CW'(1);
                state_next = S_READ;
              end
            end
            cale_pkg::CMD_REMOVE_AT: begin
              if (pos_ext >= cnt_ext) begin
                res_status_next = cale_pkg::ST_RANGE;
              end else begin
                mem_raddr = head + pos_slot;
                if (rem_front) begin
                  src_next     = head + pos_slot - SW'(1);
                  step_up_next = 1'b0;
                  left_next    = CW'(pos_ext);
                  head_next    = head + SW'(1);
                end else begin
                  src_next     = head + pos_slot + SW'(1);
                  step_up_next = 1'b1;
                  left_next    = CW'(cnt_ext - pos_ext - MW'(1));
                end
                cnt_next   = cnt - CW'(1);
                state_next = S_READ;
              end
            end
            cale_pkg::CMD_CONTAINS: begin
              src_next     = head;
              step_up_next = 1'b1;
              left_next    = cnt;
              state_next   = S_SCAN;
            end
            cale_pkg::CMD_CLEAR: begin
              head_next = '0;
              cnt_next  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_rd_next = mem_rdata;
        state_next  = (cmd_q == cale_pkg::CMD_REMOVE_AT) ? S_MOVE : S_DONE;
      end
      S_MOVE: begin
        // read one entry ahead while the previous one is written back
        if (pend) begin
          mem_we = 1'b1;
        end
        if (left != '0) begin
          wr_addr_next = step_dst;
          src_next     = step_up ? (src + SW'(1)) : (src - SW'(1));
          left_next    = left - CW'(1);
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = (cmd_q == cale_pkg::CMD_INSERT) ? S_FINAL : S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (pend && (mem_rdata == val_q)) begin
          res_found_next = 1'b1;
          pend_next      = 1'b0;
          state_next     = S_DONE;
        end else if (left != '0) begin
          src_next  = src + SW'(1);
          left_next = left - CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = S_DONE;
        end
      end
      S_FINAL: begin
        mem_we     = 1'b1;
        mem_waddr  = fin_addr;
        mem_wdata  = val_q;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      cnt          <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src        <= src_next;
    wr_addr    <= wr_addr_next;
    fin_addr   <= fin_addr_next;
    left       <= left_next;
    step_up    <= step_up_next;
    cmd_q      <= cmd_q_next;
    val_q      <= val_q_next;
    res_rd     <= res_rd_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (out_load) begin
      status     <= res_status;
      read_value <= rd_wide[31:0];
      found      <= res_found;
      count      <= cnt_wide[cale_pkg::CNT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer idle right after a command transaction");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_SCAN || state == S_DONE) |-> !mem_we)
    else $error("store written in a read-only phase");

  a_move_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && pend && left != '0) |-> (mem_waddr != mem_raddr))
    else $error("shift reads the slot it writes");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_DONE))
    else $error("result presented outside the done phase");
`endif

endmodule

FILE: tb/circular_array_list_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_array_list_engine: a directed command table, then
// random command streams, checked against the table's expected results or an in-bench list predictor.
// Depends on cale_pkg and the engine RTL.
module circular_array_list_engine_tb;

  localparam int LIST_DEPTH     = 16;
  localparam int RANDOM_ITEMS   = 1410;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int MAX_REPORTS    = 10;

  localparam logic [cale_pkg::CMD_W-1:0] CMD_RESERVED_MIN = 4'd10;
  localparam logic [cale_pkg::CMD_W-1:0] CMD_RESERVED_MAX = {cale_pkg::CMD_W{1'b1}};

  typedef logic [cale_pkg::CMD_W-1:0] cmd_code_t;
  typedef logic [cale_pkg::POS_W-1:0] pos_t;
  typedef logic [cale_pkg::VAL_W-1:0] val_t;
  typedef logic [cale_pkg::CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [cale_pkg::STAT_W-1:0] status;
    logic [cale_pkg::VAL_W-1:0]  rd;
    logic                        hit;
    logic [cale_pkg::CNT_W-1:0]  cnt;
  } list_result_t;

  typedef struct {
    cmd_code_t         c;
    pos_t              p;
    val_t              v;
    int                reps;
    bit                typed;
    list_result_t      want;
  } table_row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_mode_t;

  logic                        clk;
  logic                        rst          = 1'b1;
  logic                        cmd_valid    = 1'b0;
  logic                        cmd_stall;
  logic [cale_pkg::CMD_W-1:0]  cmd          = '0;
  logic [cale_pkg::POS_W-1:0]  position     = '0;
  logic [cale_pkg::VAL_W-1:0]  item_value   = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  logic [cale_pkg::STAT_W-1:0] status;
  logic [cale_pkg::VAL_W-1:0]  read_value;
  logic                        found;
  logic [cale_pkg::CNT_W-1:0]  count;

  circular_array_list_engine #(
    .CAPACITY  (LIST_DEPTH),
    .DATA_WIDTH(cale_pkg::VAL_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .position    (position),
    .item_value  (item_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status      (status),
    .read_value  (read_value),
    .found       (found),
    .count       (count)
  );

  // predicted list state
  val_t             model_store [LIST_DEPTH];
  logic [3:0]       model_head = '0;
  int               model_fill = 0;

  list_result_t expect_q [$];
  table_row_t   cmd_table [$];

  bit           cmd_fire;
  bit           row_typed;
  list_result_t row_expect;
  int           burst_left = 0;
  int           mismatches = 0;
  int           checked = 0;
  int           hits = 0;
  int           quiet = 0;
  int           cmd_seen [16];
  int           status_seen [4];
  val_t         recent [8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [3:0] ring_slot(int k);
    return model_head + 4'(k);
  endfunction

  task automatic apply_command(input cmd_code_t c, input pos_t p,
                               input val_t v, output list_result_t r);
    int n;
    int k;
    n = model_fill;
    r = '0;
    case (c)
      cale_pkg::CMD_PUSH_FRONT: begin
        if (n == LIST_DEPTH) r.status = cale_pkg::ST_FULL;
        else begin
          model_head--;
          model_store[model_head] = v;
          model_fill++;
        end
      end
      cale_pkg::CMD_PUSH_BACK: begin
        if (n == LIST_DEPTH) r.status = cale_pkg::ST_FULL;
        else begin
          model_store[ring_slot(n)] = v;
          model_fill++;
        end
      end
      cale_pkg::CMD_INSERT: begin
        if (n == LIST_DEPTH) r.status = cale_pkg::ST_FULL;
        else if (p > n) r.status = cale_pkg::ST_RANGE;
        else begin
          // shift whichever side is shorter
          if (p < n - p) begin
            for (k = 0; k < p; k++)
              model_store[ring_slot(k) - 4'd1] = model_store[ring_slot(k)];
            model_head--;
          end else begin
            for (k = n; k > p; k--)
              model_store[ring_slot(k)] = model_store[ring_slot(k - 1)];
          end
          model_store[ring_slot(p)] = v;
          model_fill++;
        end
      end
      cale_pkg::CMD_GET: begin
        if (p >= n) r.status = cale_pkg::ST_RANGE;
        else r.rd = model_store[ring_slot(p)];
      end
      cale_pkg::CMD_SET: begin
        if (p >= n) r.status = cale_pkg::ST_RANGE;
        else begin
          r.rd = model_store[ring_slot(p)];
          model_store[ring_slot(p)] = v;
        end
      end
      cale_pkg::CMD_POP_FRONT: begin
        if (n == 0) r.status = cale_pkg::ST_EMPTY;
        else begin
          r.rd = model_store[model_head];
          model_head++;
          model_fill--;
        end
      end
      cale_pkg::CMD_POP_BACK: begin
        if (n == 0) r.status = cale_pkg::ST_EMPTY;
        else begin
          r.rd = model_store[ring_slot(n - 1)];
          model_fill--;
        end
      end
      cale_pkg::CMD_REMOVE_AT: begin
        if (p >= n) r.status = cale_pkg::ST_RANGE;
        else begin
          r.rd = model_store[ring_slot(p)];
          if (p < n - p - 1) begin
            for (k = p; k > 0; k--)
              model_store[ring_slot(k)] = model_store[ring_slot(k - 1)];
            model_head++;
          end else begin
            for (k = p; k + 1 < n; k++)
              model_store[ring_slot(k)] = model_store[ring_slot(k + 1)];
          end
          model_fill--;
        end
      end
      cale_pkg::CMD_CONTAINS: begin
        for (k = 0; k < n; k++)
          if (model_store[ring_slot(k)] == v) r.hit = 1'b1;
      end
      cale_pkg::CMD_CLEAR: begin
        model_head = '0;
        model_fill = 0;
      end
      default: ;
    endcase
    r.cnt = cnt_t'(model_fill);
  endtask

  // accepts commands into the predictor and checks results against the oldest expectation
  always @(posedge clk) begin : monitor
    list_result_t got;
    list_result_t want;
    list_result_t pred;
    bit res_fire;
    if (rst) begin
      cmd_fire = 1'b0;
    end else begin
      cmd_fire = cmd_valid && !cmd_stall;
      res_fire = result_valid && !result_stall;
      if (res_fire) begin
        got = {status, read_value, found, count};
        status_seen[status]++;
        if (found) hits++;
        if (expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result: status=%0d rd=%h found=%b count=%0d",
                     $realtime, status, read_value, found, count);
        end else begin
          want = expect_q.pop_front();
          checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch: exp status=%0d rd=%h found=%b count=%0d",
                       $realtime, want.status, want.rd, want.hit, want.cnt);
              $display("%0t:           got status=%0d rd=%h found=%b count=%0d",
                       $realtime, got.status, got.rd, got.hit, got.cnt);
            end
          end
        end
      end
      if (cmd_fire) begin
        cmd_seen[cmd]++;
        apply_command(cmd, position, item_value, pred);
        expect_q.push_back(row_typed ? row_expect : pred);
      end
      if (cmd_fire || res_fire) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $realtime, expect_q.size());
        $display("circular_array_list_engine_tb failed");
        $finish;
      end
    end
  end

  // result side backpressure in four randomly chosen modes
  always @(negedge clk) begin : stall_gen
    stall_mode_t stall_mode;
    int stall_left;
    if (stall_left <= 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 160);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:     result_stall <= (stall_left % 24) < 14;
    endcase
  end

  // drive one command transaction; called and returns at a falling edge
  task automatic issue(input cmd_code_t c, input pos_t p,
                       input val_t v, input bit typed, input list_result_t want);
    if (burst_left <= 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    row_typed  = typed;
    row_expect = want;
    cmd        <= c;
    position   <= p;
    item_value <= v;
    cmd_valid  <= 1'b1;
    do @(negedge clk); while (!cmd_fire);
    recent[3'($urandom_range(0, 7))] = v;
  endtask

  task automatic add_row(input cmd_code_t c, input pos_t p,
                         input val_t v, input int reps, input bit typed,
                         input logic [cale_pkg::STAT_W-1:0] st, input val_t rd,
                         input logic hit, input cnt_t cnt);
    table_row_t row;
    row.c = c;
    row.p = p;
    row.v = v;
    row.reps = reps;
    row.typed = typed;
    row.want = {st, rd, hit, cnt};
    cmd_table.push_back(row);
  endtask

  initial begin : stimulus
    cmd_code_t        c;
    pos_t             p;
    val_t             v;
    int               fill_goal;
    int               roll;
    foreach (recent[i]) recent[i] = $urandom;

    // empty list corner cases, then commands on a short list
    add_row(cale_pkg::CMD_GET,        8'd0,   32'h0,         1, 1,
            cale_pkg::ST_RANGE, 32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_POP_FRONT,  8'd0,   32'h0,         1, 1,
            cale_pkg::ST_EMPTY, 32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_POP_BACK,   8'd0,   32'h0,         1, 1,
            cale_pkg::ST_EMPTY, 32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_REMOVE_AT,  8'd0,   32'h0,         1, 1,
            cale_pkg::ST_RANGE, 32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_CONTAINS,   8'd0,   32'h0,         1, 1,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_INSERT,     8'd1,   32'h1,         1, 1,
            cale_pkg::ST_RANGE, 32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_INSERT,     8'd0,   32'hffff_ffff, 1, 1,
            cale_pkg::ST_OK,    32'h0,         0, 5'd1);
    add_row(cale_pkg::CMD_PUSH_BACK,  8'd0,   32'h0,         1, 1,
            cale_pkg::ST_OK,    32'h0,         0, 5'd2);
    add_row(cale_pkg::CMD_PUSH_FRONT, 8'd0,   32'h8000_0001, 1, 1,
            cale_pkg::ST_OK,    32'h0,         0, 5'd3);
    add_row(cale_pkg::CMD_GET,        8'd255, 32'h0,         1, 1,
            cale_pkg::ST_RANGE, 32'h0,         0, 5'd3);
    add_row(cale_pkg::CMD_GET,        8'd0,   32'h0,         1, 1,
            cale_pkg::ST_OK,    32'h8000_0001, 0, 5'd3);
    add_row(cale_pkg::CMD_SET,        8'd2,   32'ha5a5_a5a5, 1, 1,
            cale_pkg::ST_OK,    32'h0,         0, 5'd3);
    add_row(cale_pkg::CMD_CONTAINS,   8'd0,   32'hffff_ffff, 1, 1,
            cale_pkg::ST_OK,    32'h0,         1, 5'd3);
    add_row(CMD_RESERVED_MAX,         8'd255, 32'hffff_ffff, 1, 1,
            cale_pkg::ST_OK,    32'h0,         0, 5'd3);
    // fill to capacity, then the full store cases
    add_row(cale_pkg::CMD_PUSH_BACK,  8'd0,   32'h1234_5600, 13, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_PUSH_FRONT, 8'd0,   32'h5,         1, 1,
            cale_pkg::ST_FULL,  32'h0,         0, 5'd16);
    add_row(cale_pkg::CMD_PUSH_BACK,  8'd0,   32'h6,         1, 1,
            cale_pkg::ST_FULL,  32'h0,         0, 5'd16);
    add_row(cale_pkg::CMD_INSERT,     8'd255, 32'h7,         1, 1,
            cale_pkg::ST_FULL,  32'h0,         0, 5'd16);
    add_row(cale_pkg::CMD_REMOVE_AT,  8'd16,  32'h0,         1, 1,
            cale_pkg::ST_RANGE, 32'h0,         0, 5'd16);
    // shifts on both sides
    add_row(cale_pkg::CMD_REMOVE_AT,  8'd3,   32'h0,         1, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_REMOVE_AT,  8'd12,  32'h0,         1, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_INSERT,     8'd2,   32'hdead_beef, 1, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_INSERT,     8'd13,  32'h0bad_f00d, 1, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_POP_FRONT,  8'd0,   32'h0,         1, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_POP_BACK,   8'd0,   32'h0,         1, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_INSERT,     8'd14,  32'h5a5a_5a5a, 1, 0,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);
    add_row(cale_pkg::CMD_INSERT,     8'd16,  32'h0,         1, 1,
            cale_pkg::ST_RANGE, 32'h0,         0, 5'd15);
    add_row(cale_pkg::CMD_CLEAR,      8'd0,   32'h0,         1, 1,
            cale_pkg::ST_OK,    32'h0,         0, 5'd0);

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (cmd_table[i])
      for (int k = 0; k < cmd_table[i].reps; k++)
        issue(cmd_table[i].c, cmd_table[i].p, cmd_table[i].v + val_t'(k),
              cmd_table[i].typed, cmd_table[i].want);

    fill_goal = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) fill_goal = $urandom_range(0, 4) * 4;
      // let the engine drain completely now and then
      if (n % 350 == 175) begin
        cmd_valid <= 1'b0;
        do @(negedge clk); while (expect_q.size() != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        c = cmd_code_t'($urandom_range(CMD_RESERVED_MIN, CMD_RESERVED_MAX));
      end else if (roll < 5) begin
        c = cale_pkg::CMD_CLEAR;
      end else if (roll < 50) begin
        // steer the fill level toward the current goal
        if (model_fill < fill_goal || (model_fill == fill_goal && $urandom_range(0, 1)))
          case ($urandom_range(0, 2))
            0:       c = cale_pkg::CMD_PUSH_FRONT;
            1:       c = cale_pkg::CMD_PUSH_BACK;
            default: c = cale_pkg::CMD_INSERT;
          endcase
        else
          case ($urandom_range(0, 2))
            0:       c = cale_pkg::CMD_POP_FRONT;
            1:       c = cale_pkg::CMD_POP_BACK;
            default: c = cale_pkg::CMD_REMOVE_AT;
          endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       c = cale_pkg::CMD_GET;
          1:       c = cale_pkg::CMD_SET;
          2:       c = cale_pkg::CMD_CONTAINS;
          default: c = cale_pkg::CMD_INSERT;
        endcase
      end
      p = ($urandom_range(0, 9) == 0) ? pos_t'($urandom_range(0, 255))
                                      : pos_t'($urandom_range(0, model_fill));
      v = ($urandom_range(0, 2) == 0) ? recent[3'($urandom_range(0, 7))] : val_t'($urandom);
      issue(c, p, v, 1'b0, '0);
    end

    cmd_valid <= 1'b0;
    do @(negedge clk); while (expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d inserts, %0d removes, %0d contains (%0d hits), %0d results checked",
             cmd_seen[cale_pkg::CMD_INSERT], cmd_seen[cale_pkg::CMD_REMOVE_AT],
             cmd_seen[cale_pkg::CMD_CONTAINS], hits, checked);
    $display("status mix: ok %0d, out of range %0d, full %0d, empty %0d; mismatches %0d",
             status_seen[cale_pkg::ST_OK], status_seen[cale_pkg::ST_RANGE],
             status_seen[cale_pkg::ST_FULL], status_seen[cale_pkg::ST_EMPTY], mismatches);
    if (mismatches == 0) begin
      $display("circular_array_list_engine_tb passed");
    end else begin
      $display("circular_array_list_engine_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cale_pkg.sv
rtl/circular_array_list_engine.sv
tb/circular_array_list_engine_tb.sv
